// ===== rtl/core/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Shared constants, codes and the command and result types of the sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // The sequence space is a power of two, so sequence arithmetic wraps in
  // SEQ_W bits without a modulo step.
  localparam int SEQ_W        = 3;
  localparam int SEQ_SPACE    = 1 << SEQ_W;
  localparam int PAYLOAD_BITS = 32;
  localparam int WINDOW_DEF   = 4;

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RES_REFUSED = 3'd0,
    RES_SENT    = 3'd1,
    RES_ACK_BAD = 3'd2,
    RES_ACK_OOW = 3'd3,
    RES_ACK_OK  = 3'd4,
    RES_RTX     = 3'd5
  } result_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_e;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_ACK_BAD = 2'd2,
    OP_TIMEOUT = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
  } cmd_t;

  typedef struct packed {
    result_e                 result_kind;
    logic [SEQ_W-1:0]        seq_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
    timer_e                  timer_cmd;
    logic [SEQ_W-1:0]        window_base;
    logic                    waiting;
    logic                    last;
  } res_t;

endpackage

// ===== rtl/core/gbn_front.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender front stage
// Accepts input words, turns them into commands and holds one in a register.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_i,
  input  logic [gbn_pkg::SEQ_W-1:0]       ack_num_i,
  input  logic                            checksum_ok_i,
  output logic                            cmd_valid_o,
  output gbn_pkg::cmd_t                   cmd_o,
  input  logic                            cmd_ready_i
);
  import gbn_pkg::*;

  logic  valid_q, valid_d;
  cmd_t  cmd_q, cmd_d;
  logic  accept;
  logic  keep;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // The unused kind causes nothing and is dropped here.
  assign keep = (kind_i != KIND_UNUSED);

  always_comb begin
    cmd_d         = cmd_q;
    cmd_d.payload = payload_i;
    cmd_d.ack_num = ack_num_i;
    case (kind_i)
      KIND_SEND:    cmd_d.op = OP_SEND;
      KIND_ACK:     cmd_d.op = checksum_ok_i ? OP_ACK : OP_ACK_BAD;
      KIND_TIMEOUT: cmd_d.op = OP_TIMEOUT;
      default:      cmd_d.op = OP_TIMEOUT;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (accept && keep) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== rtl/core/gbn_queue.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender command queue
// Two-entry FIFO that decouples the front stage from the execution stage.
// ----------------------------------------------------------------------------
module gbn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  gbn_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output gbn_pkg::cmd_t pop_data_o
);
  import gbn_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/gbn_back.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender execution stage
// Holds the window state and payload buffer, carries out commands and drives
// the result register.
// ----------------------------------------------------------------------------
module gbn_back #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  gbn_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gbn_pkg::res_t res_o
);
  import gbn_pkg::*;

  // Usable window is capped so that sequence numbers never become ambiguous.
  localparam int EffWin = (WINDOW < SEQ_SPACE - 1) ? WINDOW : SEQ_SPACE - 1;
  localparam int IdxW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SumW   = IdxW + SEQ_W + 1;
  localparam logic [SEQ_W-1:0] EffWinC = SEQ_W'(EffWin);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RTX  = 1'b1;

  // Sums here stay below twice the depth, so one compare and subtract wraps.
  function automatic logic [IdxW-1:0] wrap_idx(input logic [SumW-1:0] s);
    logic [SumW-1:0] t;
    t = (s >= SumW'(WINDOW)) ? s - SumW'(WINDOW) : s;
    return t[IdxW-1:0];
  endfunction

  logic                    st_q, st_d;
  logic [SEQ_W-1:0]        base_q, base_d;
  logic [SEQ_W-1:0]        next_q, next_d;
  logic [SEQ_W-1:0]        flight_q, flight_d;
  logic                    wait_q, wait_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic [SEQ_W-1:0]        idx_q, idx_d;
  logic                    out_valid_q;
  res_t                    res_q, res_d;

  logic [PAYLOAD_BITS-1:0] mem_q [WINDOW];
  logic [PAYLOAD_BITS-1:0] rd_data_q;
  logic                    wr_en, rd_en;
  logic [IdxW-1:0]         wr_addr, rd_addr;

  logic                    out_free, load;
  logic [SEQ_W-1:0]        off, flight_left;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign off         = cmd_i.ack_num - base_q;
  assign flight_left = flight_q - off - SEQ_W'(1);

  always_comb begin
    st_d        = st_q;
    base_d      = base_q;
    next_d      = next_q;
    flight_d    = flight_q;
    wait_d      = wait_q;
    head_d      = head_q;
    idx_d       = idx_q;
    wr_en       = 1'b0;
    wr_addr     = wrap_idx(SumW'(head_q) + SumW'(flight_q));
    rd_en       = 1'b0;
    rd_addr     = head_q;
    load        = 1'b0;
    cmd_ready_o = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;

    case (st_q)
      ST_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          case (cmd_i.op)
            OP_SEND: begin
              load              = 1'b1;
              res_d.result_kind = RES_REFUSED;
              if (wait_q) begin
                wait_d = 1'b1;
              end else if (flight_q >= EffWinC) begin
                wait_d = 1'b1;
              end else begin
                wr_en             = 1'b1;
                res_d.result_kind = RES_SENT;
                res_d.seq_out     = next_q;
                res_d.payload_out = cmd_i.payload;
                res_d.timer_cmd   = (flight_q == '0) ? TMR_START : TMR_NONE;
                next_d            = next_q + SEQ_W'(1);
                flight_d          = flight_q + SEQ_W'(1);
                if (flight_d >= EffWinC) begin
                  wait_d = 1'b1;
                end
              end
            end
            OP_ACK_BAD: begin
              load              = 1'b1;
              res_d.result_kind = RES_ACK_BAD;
            end
            OP_ACK: begin
              load = 1'b1;
              if (off >= flight_q) begin
                res_d.result_kind = RES_ACK_OOW;
              end else begin
                res_d.result_kind = RES_ACK_OK;
                base_d            = cmd_i.ack_num + SEQ_W'(1);
                head_d            = wrap_idx(SumW'(head_q) + SumW'(off) + SumW'(1));
                flight_d          = flight_left;
                wait_d            = 1'b0;
                res_d.timer_cmd   = (flight_left == '0) ? TMR_STOP : TMR_RESTART;
              end
            end
            OP_TIMEOUT: begin
              if (flight_q != '0) begin
                rd_en = 1'b1;
                idx_d = '0;
                st_d  = ST_RTX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RTX: begin
        if (out_free) begin
          load              = 1'b1;
          res_d.result_kind = RES_RTX;
          res_d.seq_out     = base_q + idx_q;
          res_d.payload_out = rd_data_q;
          res_d.timer_cmd   = (idx_q == '0) ? TMR_RESTART : TMR_NONE;
          res_d.last        = (idx_q + SEQ_W'(1) == flight_q);
          if (res_d.last) begin
            st_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + SEQ_W'(1);
            rd_en   = 1'b1;
            rd_addr = wrap_idx(SumW'(head_q) + SumW'(idx_q) + SumW'(1));
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    res_d.window_base = base_d;
    res_d.waiting     = wait_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      base_q      <= '0;
      next_q      <= '0;
      flight_q    <= '0;
      wait_q      <= 1'b0;
      head_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      base_q   <= base_d;
      next_q   <= next_d;
      flight_q <= flight_d;
      wait_q   <= wait_d;
      head_q   <= head_d;
      idx_q    <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cmd_i.payload;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

// ===== rtl/core/go_back_n_sender_top.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender
// Sender side of a Go-Back-N ARQ link with a cumulative-ack sliding window.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_ready_o) takes one word per event:
// a payload to send, an arriving acknowledgement, or a retransmit timeout.
// The output channel (out_valid_o / out_ready_i) gives one word per result:
// sends and acks give one result each, a timeout gives one retransmission per
// buffered packet, oldest first, with last_o marking the final word. A timeout
// on an empty window and the unused event kind give no result.
// Flow: an event passes a front register, a two-entry command queue and
// the execution stage, which registers its result. Sends and acks are
// carried out one per cycle while the receiver takes results. A timeout
// first reads the payload buffer, then emits one retransmission per cycle
// while the receiver takes them, and takes no new command until the last
// word is loaded. The single payload buffer read port sets that rate.
// Reset clears the window pointers, the in-flight count and the waiting flag;
// the payload buffer is not cleared, since only written entries are ever read.
// When the receiver stalls, the result register holds its word, the execution
// stage stops, the queue fills, and then in_ready_o drops.
// ----------------------------------------------------------------------------
module go_back_n_sender_top #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_i,
  input  logic [gbn_pkg::SEQ_W-1:0]        ack_num_i,
  input  logic                             checksum_ok_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       result_kind_o,
  output logic [gbn_pkg::SEQ_W-1:0]        seq_out_o,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_out_o,
  output logic [1:0]                       timer_cmd_o,
  output logic [gbn_pkg::SEQ_W-1:0]        window_base_o,
  output logic                             waiting_o,
  output logic                             last_o
);
  import gbn_pkg::*;

  // Front stage to queue.
  logic front_valid, front_ready;
  cmd_t front_cmd;

  // Queue to execution stage.
  logic q_valid, q_ready;
  cmd_t q_cmd;

  res_t res;

  gbn_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .payload_i     (payload_i),
    .ack_num_i     (ack_num_i),
    .checksum_ok_i (checksum_ok_i),
    .cmd_valid_o   (front_valid),
    .cmd_o         (front_cmd),
    .cmd_ready_i   (front_ready)
  );

  gbn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  gbn_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign result_kind_o = res.result_kind;
  assign seq_out_o     = res.seq_out;
  assign payload_out_o = res.payload_out;
  assign timer_cmd_o   = res.timer_cmd;
  assign window_base_o = res.window_base;
  assign waiting_o     = res.waiting;
  assign last_o        = res.last;

endmodule

// ===== rtl/core/gbn_checker.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender port checker
// Watches the top-level ports and flags results that break the sender rules.
// ----------------------------------------------------------------------------
module gbn_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [2:0]                       result_kind_i,
  input logic [gbn_pkg::SEQ_W-1:0]        seq_out_i,
  input logic [gbn_pkg::PAYLOAD_BITS-1:0] payload_out_i,
  input logic [1:0]                       timer_cmd_i,
  input logic                             waiting_i,
  input logic                             last_i
);
  import gbn_pkg::*;

  // Only sends and retransmissions carry a packet; all else is a single word.
  a_no_packet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i != RES_SENT && result_kind_i != RES_RTX
    |-> seq_out_i == '0 && payload_out_i == '0 && last_i)
    else $error("non-packet result carries packet fields or lacks last");

  // An accepted ack always reopens the window.
  a_ack_clears_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RES_ACK_OK |-> !waiting_i)
    else $error("accepted ack left the sender waiting");

  // A retransmission burst continues without gaps, with no further timer command.
  a_rtx_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && result_kind_i == RES_RTX && !last_i
    |=> out_valid_i && result_kind_i == RES_RTX && timer_cmd_i == TMR_NONE
        && seq_out_i == $past(seq_out_i) + SEQ_W'(1))
    else $error("retransmission burst broken");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i
    |=> out_valid_i && $stable(result_kind_i) && $stable(payload_out_i))
    else $error("stalled result changed");

endmodule

bind go_back_n_sender_top gbn_checker u_gbn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_i (result_kind_o),
  .seq_out_i     (seq_out_o),
  .payload_out_i (payload_out_o),
  .timer_cmd_i   (timer_cmd_o),
  .waiting_i     (waiting_o),
  .last_i        (last_o)
);

// ===== test/tb_go_back_n_sender_top.sv =====
// ----------------------------------------------------------------------------
// Go-Back-N sender testbench
// Feeds send, ack, timeout and unused events to the sender through a gapped
// valid/ready driver. A stalling monitor compares every result word with the
// output of a cycle-free model of the window kept alongside the driver.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int WINDOW     = WINDOW_DEF;
  // The window never covers the whole sequence space, so that an ack number
  // always names one packet and never two.
  localparam int USABLE     = (WINDOW < SEQ_SPACE - 1) ? WINDOW : SEQ_SPACE - 1;
  localparam int NUM_RANDOM = 200;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE     = 24;

  // One event as the driver presents it. The hold bit makes the driver wait
  // until every outstanding result word has come back before presenting it.
  typedef struct packed {
    kind_e                   kind;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_W-1:0]        ack_num;
    logic                    checksum_ok;
    logic                    hold;
  } sender_event_t;

  // Window state: payload and sequence number of each buffered packet in a
  // ring that starts at head, plus the window pointers and the waiting flag.
  typedef struct packed {
    logic [WINDOW-1:0][PAYLOAD_BITS-1:0] pay;
    logic [WINDOW-1:0][SEQ_W-1:0]        seq;
    logic [SEQ_W-1:0]                    base;
    logic [SEQ_W-1:0]                    next;
    int                                  in_flight;
    int                                  head;
    logic                                waiting;
  } window_state_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              kind_i        = KIND_SEND;
  logic [PAYLOAD_BITS-1:0] payload_i     = '0;
  logic [SEQ_W-1:0]        ack_num_i     = '0;
  logic                    checksum_ok_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [2:0]              result_kind_o;
  logic [SEQ_W-1:0]        seq_out_o;
  logic [PAYLOAD_BITS-1:0] payload_out_o;
  logic [1:0]              timer_cmd_o;
  logic [SEQ_W-1:0]        window_base_o;
  logic                    waiting_o;
  logic                    last_o;

  sender_event_t event_q[$];     // events waiting for the driver
  res_t          expected_q[$];  // result words not yet seen at the output
  window_state_t sent_window;    // window as of the last accepted event
  window_state_t plan_window;    // window as the stimulus generator sees it
  sender_event_t cur_event;
  int            gap_left;
  int            stall_left;
  int            send_calm;
  int            recv_calm;
  int            idle_cycles;
  int            failures;

  go_back_n_sender_top #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .payload_i    (payload_i),
    .ack_num_i    (ack_num_i),
    .checksum_ok_i(checksum_ok_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .seq_out_o    (seq_out_o),
    .payload_out_o(payload_out_o),
    .timer_cmd_o  (timer_cmd_o),
    .window_base_o(window_base_o),
    .waiting_o    (waiting_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Applies one event to a window state. With record set, the result words
  // it causes are queued as expectations; the stimulus generator calls it
  // with record clear only to follow the window it is steering.
  function automatic void apply_event(inout window_state_t st, input sender_event_t ev,
                                      input bit record);
    res_t             word;
    logic [SEQ_W-1:0] offset;
    int               slot;
    word      = '0;
    word.last = 1'b1;
    case (ev.kind)
      KIND_SEND: begin
        if (st.waiting) begin
          word.result_kind = RES_REFUSED;
        end else if (st.in_flight >= USABLE) begin
          // A full window that is not yet marked waiting refuses the send
          // and turns waiting on from here.
          st.waiting       = 1'b1;
          word.result_kind = RES_REFUSED;
        end else begin
          slot             = (st.head + st.in_flight) % WINDOW;
          st.pay[slot]     = ev.payload;
          st.seq[slot]     = st.next;
          word.result_kind = RES_SENT;
          word.seq_out     = st.next;
          word.payload_out = ev.payload;
          // The timer only starts when the first packet enters an empty window.
          if (st.in_flight == 0) begin
            word.timer_cmd = TMR_START;
          end
          st.next      = st.next + 1'b1;
          st.in_flight = st.in_flight + 1;
          if (st.in_flight >= USABLE) begin
            st.waiting = 1'b1;
          end
        end
        word.window_base = st.base;
        word.waiting     = st.waiting;
        if (record) begin
          expected_q.push_back(word);
        end
      end
      KIND_ACK: begin
        // The distance from base wraps with the sequence width, so an ack
        // behind base lands far ahead and falls outside the window.
        offset = ev.ack_num - st.base;
        if (!ev.checksum_ok) begin
          word.result_kind = RES_ACK_BAD;
        end else if (int'(offset) >= st.in_flight) begin
          word.result_kind = RES_ACK_OOW;
        end else begin
          st.base      = st.base + offset + 1'b1;
          st.head      = (st.head + int'(offset) + 1) % WINDOW;
          st.in_flight = st.in_flight - int'(offset) - 1;
          st.waiting   = 1'b0;
          word.result_kind = RES_ACK_OK;
          if (st.in_flight == 0) begin
            word.timer_cmd = TMR_STOP;
          end else begin
            word.timer_cmd = TMR_RESTART;
          end
        end
        word.window_base = st.base;
        word.waiting     = st.waiting;
        if (record) begin
          expected_q.push_back(word);
        end
      end
      KIND_TIMEOUT: begin
        // Every buffered packet goes out again, oldest first. The first word
        // restarts the timer; an empty window gives nothing at all.
        for (int i = 0; i < st.in_flight; i++) begin
          slot             = (st.head + i) % WINDOW;
          word             = '0;
          word.result_kind = RES_RTX;
          word.seq_out     = st.seq[slot];
          word.payload_out = st.pay[slot];
          if (i == 0) begin
            word.timer_cmd = TMR_RESTART;
          end
          word.window_base = st.base;
          word.waiting     = st.waiting;
          word.last        = (i + 1 == st.in_flight);
          if (record) begin
            expected_q.push_back(word);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Queues one event for the driver and follows its effect on the window.
  function automatic void plan_event(kind_e kind, logic [PAYLOAD_BITS-1:0] payload,
                                     logic [SEQ_W-1:0] ack_num, logic checksum_ok,
                                     logic hold);
    sender_event_t ev;
    ev.kind        = kind;
    ev.payload     = payload;
    ev.ack_num     = ack_num;
    ev.checksum_ok = checksum_ok;
    ev.hold        = hold;
    event_q.push_back(ev);
    apply_event(plan_window, ev, 1'b0);
  endfunction

  // Gap or stall length: mostly none or short, a few long, and now and then
  // a run of words with no idling at all.
  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Builds the stimulus up front. Most random events are well formed for the
  // window at that point (sends while room is left, acks inside the window)
  // so that the window fills, wraps and slides; the rest are refused sends,
  // bad checksums, acks outside the window, timeouts and unused events.
  task automatic build_stimulus();
    int                     counted;
    int                     roll;
    logic [SEQ_W-1:0]       ack;
    kind_e                  kind;
    // Directed part: empty window cases first, then a window filled with the
    // extreme payloads, refusal while waiting, the ignored acks, a full
    // retransmission, a partial and a complete cumulative ack.
    plan_event(KIND_ACK, '0, 3'd0, 1'b1, 1'b0);
    plan_event(KIND_TIMEOUT, '0, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_UNUSED, '1, '1, 1'b1, 1'b0);
    plan_event(KIND_SEND, '0, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, '1, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, 32'h5A5A_5A5A, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, 32'hA5A5_A5A5, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, $urandom, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_ACK, '0, 3'd1, 1'b0, 1'b0);
    plan_event(KIND_ACK, '0, 3'd7, 1'b1, 1'b0);
    plan_event(KIND_TIMEOUT, '0, 3'd0, 1'b0, 1'b1);
    plan_event(KIND_ACK, '0, 3'd1, 1'b1, 1'b0);
    plan_event(KIND_SEND, $urandom, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, $urandom, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_SEND, $urandom, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_TIMEOUT, '0, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_ACK, '0, 3'd5, 1'b1, 1'b0);
    plan_event(KIND_TIMEOUT, '0, 3'd0, 1'b0, 1'b0);
    plan_event(KIND_ACK, '0, 3'd5, 1'b1, 1'b0);
    plan_event(KIND_ACK, '0, 3'd6, 1'b1, 1'b0);

    counted = 0;
    while (counted < NUM_RANDOM) begin
      roll = $urandom_range(0, 99);
      if (plan_window.waiting) begin
        if (roll < 60) kind = KIND_ACK;
        else if (roll < 70) kind = KIND_SEND;
        else if (roll < 80) kind = KIND_TIMEOUT;
        else if (roll < 96) kind = KIND_ACK;
        else kind = KIND_UNUSED;
      end else begin
        if (roll < 50) kind = KIND_SEND;
        else if (roll < 80) kind = KIND_ACK;
        else if (roll < 96) kind = KIND_TIMEOUT;
        else kind = KIND_UNUSED;
      end
      counted++;
      roll = $urandom_range(0, 99);
      if (kind == KIND_ACK && plan_window.in_flight > 0 && roll < 70) begin
        ack = plan_window.base + SEQ_W'($urandom_range(0, plan_window.in_flight - 1));
        plan_event(kind, pick_payload(), ack, 1'b1, $urandom_range(0, 39) == 0);
      end else if (kind == KIND_ACK && roll < 85) begin
        ack = plan_window.base + SEQ_W'($urandom_range(plan_window.in_flight, SEQ_SPACE - 1));
        plan_event(kind, pick_payload(), ack, 1'b1, $urandom_range(0, 39) == 0);
      end else if (kind == KIND_ACK) begin
        plan_event(kind, pick_payload(), SEQ_W'($urandom), 1'b0, 1'b0);
      end else begin
        plan_event(kind, pick_payload(), SEQ_W'($urandom), 1'($urandom),
                   $urandom_range(0, 39) == 0);
      end
    end
  endtask

  // Driver: presents one event at a time. An event is handed to the window
  // model at the edge that accepts it, then the gap before the next one runs
  // out; a held event waits until no result word is outstanding.
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        apply_event(sent_window, cur_event, 1'b1);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (event_q.size() > 0 &&
                     !(event_q[0].hold && expected_q.size() != 0)) begin
          cur_event = event_q.pop_front();
          kind_i        <= cur_event.kind;
          payload_i     <= cur_event.payload;
          ack_num_i     <= cur_event.ack_num;
          checksum_ok_i <= cur_event.checksum_ok;
          busy     = 1'b1;
          gap_left = pick_gap(send_calm);
        end
      end
      in_valid_i <= busy;
    end
  end

  function automatic void check_field(string name, logic [PAYLOAD_BITS-1:0] expected,
                                      logic [PAYLOAD_BITS-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      failures++;
    end
  endfunction

  // Monitor: takes result words with random stalls and checks each one
  // against the oldest outstanding expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_word;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with no outstanding expectation: result_kind %0d",
                 result_kind_o);
          failures++;
        end else begin
          exp_word = expected_q.pop_front();
          check_field("result_kind", 32'(exp_word.result_kind), 32'(result_kind_o));
          check_field("seq_out", 32'(exp_word.seq_out), 32'(seq_out_o));
          check_field("payload_out", exp_word.payload_out, payload_out_o);
          check_field("timer_cmd", 32'(exp_word.timer_cmd), 32'(timer_cmd_o));
          check_field("window_base", 32'(exp_word.window_base), 32'(window_base_o));
          check_field("waiting", 32'(exp_word.waiting), 32'(waiting_o));
          check_field("last", 32'(exp_word.last), 32'(last_o));
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(recv_calm);
        out_ready_i <= (stall_left == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a run in which neither channel moves a word for too long has
  // hung, whatever the cause.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_go_back_n_sender_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    failures    = 0;
    idle_cycles = 0;
    send_calm   = 0;
    recv_calm   = 0;
    sent_window = '0;
    plan_window = '0;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every event accepted, every result seen, then a quiet stretch so that
    // a stray extra word still gets caught.
    while (event_q.size() != 0 || in_valid_i || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_go_back_n_sender_top passed");
    end else begin
      $display("tb_go_back_n_sender_top failed");
    end
    $finish;
  end

endmodule
